>>> src/dpu_pkg.sv
package dpu_pkg;

   localparam int IDX_FIELD_BITS = 12;
   localparam int RES_LIMIT      = 17;
   localparam int TABLE_W        = 5;
   localparam int RANGE_W        = 17;
   localparam int CFG_W          = 13;
   localparam int COUNT_W        = 5;
   localparam int IB_W           = 4;
   localparam logic [IB_W-1:0] IB_RESET = 4'd10;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WCALC,
      ST_PEND_RD,
      ST_PEND_GO,
      ST_VAL_WAIT,
      ST_IDX_CHK,
      ST_IDX_WAIT,
      ST_VAL_CHK,
      ST_FIN
   } state_type;

   typedef enum logic {
      MODE_LOAD,
      MODE_CFG
   } calc_mode_type;

   typedef enum logic {
      FUNC_LOAD,
      FUNC_DECODE
   } func_type;

   typedef struct packed {
      logic load;
      logic start;
   } fr_ctrl_type;

   typedef struct packed {
      logic [IDX_FIELD_BITS-1:0] var_index;
      logic [15:0]               pair_value;
      logic                      pair_valid;
      logic                      record_end;
      logic                      index_error;
   } rsp_type;

endpackage

>>> src/delta_pair_unpacker_core.sv
// load and config write: the width calculator shifts the range less one right until zero
// decode: the field shifter walks the word bit by bit, an index field then a value field per pair
// a result waits in the hold stage until the next result or the end of the word pushes it out
// reset: synchronous, clears control state, index width back to 10 bits (range 1024)
// width table contents are undefined after reset until loaded
module delta_pair_unpacker_core
   import dpu_pkg::*;
#(
   parameter int NUM_VARS       = 1024,
   parameter int WORD_BITS      = 32,
   parameter int MAX_VALUE_BITS = 16
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // var_number[10:0], var_range[27:11], packed_word[59:28], start_record[60]
   input  logic [63:0]      req_tdata,
   // func
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // var_index[11:0], pair_value[27:12]
   output logic [31:0]      rsp_tdata,
   // pair_valid, record_end, index_error
   output logic [2:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   localparam int FIELD_W = (MAX_VALUE_BITS > IDX_FIELD_BITS) ? MAX_VALUE_BITS : IDX_FIELD_BITS;
   localparam int LEN_W   = $clog2(FIELD_W + 1);
   localparam int POS_W   = $clog2(WORD_BITS + MAX_VALUE_BITS + 2);
   localparam int CMP_W   = POS_W + 1;
   localparam int AW      = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

   state_type state_ff, state_in;

   logic [10:0]           req_num;
   logic [RANGE_W-1:0]    req_range;
   logic [31:0]           req_word;
   logic                  req_start;
   logic                  req_acc;
   logic                  csr_acc;
   logic                  num_ok;
   logic                  active_new;

   logic                  active_ff, active_in;
   logic                  pending_ff, pending_in;
   logic [IDX_FIELD_BITS-1:0] pidx_ff, pidx_in;
   logic [IDX_FIELD_BITS-1:0] idx_ff, idx_in;
   logic [COUNT_W-1:0]    n_ff, n_in;
   logic                  cont_ff, cont_in;
   calc_mode_type         mode_ff, mode_in;
   logic [AW-1:0]         waddr_ff, waddr_in;
   logic [IB_W-1:0]       ib_ff, ib_in;

   logic                  calc_start;
   logic [RANGE_W-1:0]    calc_value;
   logic                  calc_done;
   logic [COUNT_W-1:0]    calc_res;

   logic                  mem_we;
   logic [TABLE_W-1:0]    mem_wdata;
   logic [AW-1:0]         mem_raddr;
   logic [TABLE_W-1:0]    mem_rdata;
   logic [RANGE_W-1:0]    num_m1;
   logic [RANGE_W-1:0]    raddr_full;

   fr_ctrl_type           fr_ctrl;
   logic [LEN_W-1:0]      fr_len;
   logic                  fr_busy;
   logic [FIELD_W-1:0]    fr_field;
   logic [POS_W-1:0]      fr_pos;
   logic [IDX_FIELD_BITS-1:0] fld_idx;

   logic                  idx_fits;
   logic                  val_fits;
   logic                  limit_hit;
   logic                  idx_zero;
   logic                  idx_over;

   logic                  hold_valid_ff, hold_valid_in;
   rsp_type               hold_ff, hold_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_free;
   logic                  can_emit;
   logic                  emit;
   rsp_type               emit_res;
   logic                  fin_push;

   assign req_num   = req_tdata[10:0];
   assign req_range = req_tdata[27:11];
   assign req_word  = req_tdata[59:28];
   assign req_start = req_tdata[60];

   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_acc    = csr_valid && csr_ready;

   assign num_ok     = (req_num != '0) && (32'(req_num) <= 32'(NUM_VARS));
   assign num_m1     = RANGE_W'(req_num) - RANGE_W'(1);
   assign active_new = req_start || active_ff;

   assign fld_idx   = fr_field[IDX_FIELD_BITS-1:0];
   assign idx_zero  = (fld_idx == '0);
   assign idx_over  = 32'(fld_idx) > 32'(NUM_VARS);
   assign limit_hit = (n_ff >= COUNT_W'(RES_LIMIT));
   assign idx_fits  = (CMP_W'(fr_pos) + CMP_W'(ib_ff)) <= CMP_W'(WORD_BITS);
   assign val_fits  = (CMP_W'(fr_pos) + CMP_W'(mem_rdata)) <= CMP_W'(WORD_BITS);

   assign out_free  = !out_valid_ff || rsp_tready;
   assign can_emit  = !hold_valid_ff || out_free;

   assign raddr_full = (state_ff == ST_PEND_RD) ? RANGE_W'(pidx_ff) - RANGE_W'(1)
                                                : RANGE_W'(fld_idx) - RANGE_W'(1);
   assign mem_raddr  = raddr_full[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_acc) begin
               state_in = ST_WCALC;
            end else if (req_acc) begin
               if (func_type'(req_tuser) == FUNC_LOAD) begin
                  state_in = num_ok ? ST_WCALC : ST_IDLE;
               end else if (!active_new) begin
                  state_in = ST_IDLE;
               end else if (!req_start && pending_ff) begin
                  state_in = ST_PEND_RD;
               end else begin
                  state_in = ST_IDX_CHK;
               end
            end
         end
         ST_WCALC: begin
            if (calc_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_PEND_RD:  state_in = ST_PEND_GO;
         ST_PEND_GO:  state_in = ST_VAL_WAIT;
         ST_VAL_WAIT: begin
            if (!fr_busy && can_emit) begin
               state_in = ST_IDX_CHK;
            end
         end
         ST_IDX_CHK: begin
            priority if (limit_hit) begin
               state_in = ST_FIN;
            end else if (!idx_fits) begin
               if (cont_ff || can_emit) begin
                  state_in = ST_FIN;
               end
            end else begin
               state_in = ST_IDX_WAIT;
            end
         end
         ST_IDX_WAIT: begin
            if (!fr_busy) begin
               if (idx_zero || idx_over) begin
                  if (can_emit) begin
                     state_in = ST_FIN;
                  end
               end else begin
                  state_in = ST_VAL_CHK;
               end
            end
         end
         ST_VAL_CHK:  state_in = val_fits ? ST_VAL_WAIT : ST_FIN;
         ST_FIN: begin
            if (!hold_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      calc_start    = 1'b0;
      calc_value    = req_range;
      fr_ctrl.load  = 1'b0;
      fr_ctrl.start = 1'b0;
      fr_len        = LEN_W'(ib_ff);
      emit          = 1'b0;
      emit_res      = '0;
      fin_push      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_acc) begin
               calc_start = 1'b1;
               calc_value = RANGE_W'(csr_data);
            end else if (req_acc) begin
               if (func_type'(req_tuser) == FUNC_LOAD) begin
                  calc_start = num_ok;
               end else begin
                  fr_ctrl.load = 1'b1;
               end
            end
         end
         ST_PEND_GO: begin
            fr_ctrl.start = 1'b1;
            fr_len        = LEN_W'(mem_rdata);
         end
         ST_VAL_WAIT: begin
            if (!fr_busy && can_emit) begin
               emit                = 1'b1;
               emit_res.var_index  = idx_ff;
               emit_res.pair_value = 16'(fr_field);
               emit_res.pair_valid = 1'b1;
            end
         end
         ST_IDX_CHK: begin
            if (!limit_hit) begin
               if (idx_fits) begin
                  fr_ctrl.start = 1'b1;
               end else if (!cont_ff && can_emit) begin
                  emit                = 1'b1;
                  emit_res.record_end = 1'b1;
               end
            end
         end
         ST_IDX_WAIT: begin
            if (!fr_busy && (idx_zero || idx_over) && can_emit) begin
               emit                 = 1'b1;
               emit_res.record_end  = 1'b1;
               emit_res.var_index   = idx_over ? fld_idx : '0;
               emit_res.index_error = idx_over;
            end
         end
         ST_VAL_CHK: begin
            if (val_fits) begin
               fr_ctrl.start = 1'b1;
               fr_len        = LEN_W'(mem_rdata);
            end
         end
         ST_FIN: begin
            fin_push = hold_valid_ff && out_free;
         end
         default: begin
         end
      endcase
   end

   // record and table state
   always_comb begin
      active_in  = active_ff;
      pending_in = pending_ff;
      pidx_in    = pidx_ff;
      idx_in     = idx_ff;
      n_in       = n_ff;
      cont_in    = cont_ff;
      mode_in    = mode_ff;
      waddr_in   = waddr_ff;
      ib_in      = ib_ff;
      mem_we     = 1'b0;
      mem_wdata  = (calc_res > COUNT_W'(MAX_VALUE_BITS)) ? TABLE_W'(MAX_VALUE_BITS)
                                                         : TABLE_W'(calc_res);
      if (csr_acc) begin
         mode_in = MODE_CFG;
      end else if (req_acc) begin
         if (func_type'(req_tuser) == FUNC_LOAD) begin
            mode_in  = MODE_LOAD;
            waddr_in = num_m1[AW-1:0];
         end else begin
            active_in = active_new;
            n_in      = '0;
            cont_in   = req_word[0];
            if (req_start) begin
               pending_in = 1'b0;
               pidx_in    = '0;
            end
         end
      end
      if (state_ff == ST_WCALC && calc_done) begin
         if (mode_ff == MODE_LOAD) begin
            mem_we = 1'b1;
         end else begin
            ib_in = (calc_res > COUNT_W'(IDX_FIELD_BITS)) ? IB_W'(IDX_FIELD_BITS)
                                                          : IB_W'(calc_res);
         end
      end
      if (state_ff == ST_PEND_GO) begin
         pending_in = 1'b0;
         idx_in     = pidx_ff;
      end
      if (state_ff == ST_IDX_WAIT && !fr_busy) begin
         idx_in = fld_idx;
      end
      if (state_ff == ST_VAL_CHK && !val_fits) begin
         pending_in = 1'b1;
         pidx_in    = idx_ff;
      end
      if (emit) begin
         n_in = n_ff + COUNT_W'(1);
         if (emit_res.record_end) begin
            active_in = 1'b0;
         end
      end
   end

   // hold stage decides tlast, output register faces the result channel
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      if (emit) begin
         hold_valid_in = 1'b1;
         hold_in       = emit_res;
         if (hold_valid_ff) begin
            out_in       = hold_ff;
            out_last_in  = 1'b0;
            out_valid_in = 1'b1;
         end
      end else if (fin_push) begin
         hold_valid_in = 1'b0;
         out_in        = hold_ff;
         out_last_in   = 1'b1;
         out_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= 1'b0;
         pending_ff    <= 1'b0;
         pidx_ff       <= '0;
         n_ff          <= '0;
         ib_ff         <= IB_RESET;
         mode_ff       <= MODE_LOAD;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         pending_ff    <= pending_in;
         pidx_ff       <= pidx_in;
         n_ff          <= n_in;
         ib_ff         <= ib_in;
         mode_ff       <= mode_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      idx_ff      <= idx_in;
      cont_ff     <= cont_in;
      waddr_ff    <= waddr_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   dpu_width_calc u_calc (
      .clock  (clock),
      .reset  (reset),
      .start  (calc_start),
      .value  (calc_value),
      .done   (calc_done),
      .result (calc_res)
   );

   dpu_width_ram #(
      .DEPTH (NUM_VARS),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (waddr_ff),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   dpu_field_reader #(
      .WORD_BITS (WORD_BITS),
      .FIELD_W   (FIELD_W),
      .POS_W     (POS_W),
      .LEN_W     (LEN_W)
   ) u_reader (
      .clock (clock),
      .reset (reset),
      .ctrl  (fr_ctrl),
      .word  (WORD_BITS'(req_word)),
      .len   (fr_len),
      .busy  (fr_busy),
      .field (fr_field),
      .pos   (fr_pos)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_ff.pair_value, out_ff.var_index};
   assign rsp_tuser  = {out_ff.index_error, out_ff.record_end, out_ff.pair_valid};
   assign rsp_tlast  = out_last_ff;

endmodule

>>> src/dpu_width_calc.sv
module dpu_width_calc
   import dpu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [RANGE_W-1:0] value,
   output logic               done,
   output logic [COUNT_W-1:0] result
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [RANGE_W-1:0] sh_ff, sh_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         if (value <= RANGE_W'(1)) begin
            sh_in  = '0;
            cnt_in = COUNT_W'(1);
         end else begin
            sh_in  = value - RANGE_W'(1);
            cnt_in = '0;
         end
      end else if (busy_ff) begin
         if (sh_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            sh_in  = sh_ff >> 1;
            cnt_in = cnt_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sh_ff  <= sh_in;
      cnt_ff <= cnt_in;
   end

   assign done   = done_ff;
   assign result = cnt_ff;

endmodule

>>> src/dpu_width_ram.sv
module dpu_width_ram
   import dpu_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
)
(
   input  logic               clock,
   input  logic               we,
   input  logic [AW-1:0]      waddr,
   input  logic [TABLE_W-1:0] wdata,
   input  logic [AW-1:0]      raddr,
   output logic [TABLE_W-1:0] rdata
);

   logic [TABLE_W-1:0] mem [DEPTH];
   logic [TABLE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/dpu_field_reader.sv
module dpu_field_reader
   import dpu_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int FIELD_W   = 16,
   parameter int POS_W     = 6,
   parameter int LEN_W     = 5
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  fr_ctrl_type          ctrl,
   input  logic [WORD_BITS-1:0] word,
   input  logic [LEN_W-1:0]     len,
   output logic                 busy,
   output logic [FIELD_W-1:0]   field,
   output logic [POS_W-1:0]     pos
);

   localparam int K_W = $clog2(FIELD_W);

   logic [WORD_BITS-1:0] sh_ff, sh_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [FIELD_W-1:0]   field_ff, field_in;
   logic [K_W-1:0]       k_ff, k_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 busy_ff, busy_in;

   always_comb begin
      sh_in    = sh_ff;
      pos_in   = pos_ff;
      field_in = field_ff;
      k_in     = k_ff;
      len_in   = len_ff;
      busy_in  = busy_ff;
      if (ctrl.load) begin
         // bit 0 is the continuation flag, fields start at bit 1
         sh_in   = word >> 1;
         pos_in  = POS_W'(1);
         busy_in = 1'b0;
      end else if (ctrl.start) begin
         field_in = '0;
         k_in     = '0;
         len_in   = len;
         busy_in  = (len != '0);
      end else if (busy_ff) begin
         field_in[k_ff] = sh_ff[0];
         sh_in          = sh_ff >> 1;
         pos_in         = pos_ff + POS_W'(1);
         k_in           = k_ff + K_W'(1);
         if (LEN_W'(k_ff) + LEN_W'(1) == len_ff) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      sh_ff    <= sh_in;
      pos_ff   <= pos_in;
      field_ff <= field_in;
      k_ff     <= k_in;
      len_ff   <= len_in;
   end

   assign busy  = busy_ff;
   assign field = field_ff;
   assign pos   = pos_ff;

endmodule

>>> verif/tb_delta_pair_unpacker_core.sv
module tb_delta_pair_unpacker_core;
   import dpu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_VARS       = 1024;
   localparam int WORD_BITS      = 32;
   localparam int MAX_VALUE_BITS = 16;
   localparam int SETTLE_CYCLES  = 200;

   typedef struct {
      func_type    func;
      logic [10:0] var_number;
      logic [16:0] var_range;
      logic [31:0] packed_word;
      logic        start_record;
   } req_item_t;

   typedef struct {
      logic [11:0] var_index;
      logic [15:0] pair_value;
      logic        pair_valid;
      logic        record_end;
      logic        index_error;
      logic        last;
   } pair_rsp_t;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [63:0]      req_tdata;
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [31:0]      rsp_tdata;
   logic [2:0]       rsp_tuser;
   logic             rsp_tlast;
   logic             csr_valid;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data;

   // predicted block state
   logic [4:0]       val_width [NUM_VARS];
   int               bit_pos;
   logic             value_wait;
   logic [11:0]      wait_index;
   logic             in_record;
   int unsigned      index_range;

   // widths as the stimulus side sees them when it encodes records
   int               plan_width [NUM_VARS];
   int               plan_ib;

   req_item_t        req_items [$];
   req_item_t        cur_req;
   pair_rsp_t        pairs_due [$];

   int               send_idle_pct;
   int               rsp_stall_pct;
   int               queued;
   int               failures;
   int               loads_sent;
   int               words_sent;
   int               pairs_seen;
   int               ends_seen;
   int               errors_seen;

   delta_pair_unpacker_core #(
      .NUM_VARS       (NUM_VARS),
      .WORD_BITS      (WORD_BITS),
      .MAX_VALUE_BITS (MAX_VALUE_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int range_bits(input int unsigned r);
      int n;
      n = 0;
      if (r <= 1) return 1;
      while (n < 31 && (32'd1 << n) < r) n++;
      return n;
   endfunction

   function automatic int unsigned take(input logic [31:0] wd, input int pos, input int w);
      return int'((64'(wd) >> pos) & ((64'd1 << w) - 64'd1));
   endfunction

   function automatic logic [31:0] place(input logic [31:0] wd, input int pos, input int w,
                                         input int unsigned v);
      logic [63:0] mask;
      mask = ((64'd1 << w) - 64'd1) << pos;
      return 32'((64'(wd) & ~mask) | ((64'(v) << pos) & mask));
   endfunction

   function automatic pair_rsp_t make_pair(input int unsigned idx, input int unsigned val,
                                           input logic valid, input logic rend, input logic err);
      pair_rsp_t r;
      r.var_index   = idx[11:0];
      r.pair_value  = val[15:0];
      r.pair_valid  = valid;
      r.record_end  = rend;
      r.index_error = err;
      r.last        = 1'b0;
      return r;
   endfunction

   task automatic predict_pairs(input req_item_t it);
      pair_rsp_t   out_q [$];
      int          ib;
      int          w;
      int unsigned idx;
      if (it.func == FUNC_LOAD) begin
         if (it.var_number >= 1 && it.var_number <= NUM_VARS) begin
            w = range_bits(it.var_range);
            if (w > MAX_VALUE_BITS) w = MAX_VALUE_BITS;
            val_width[it.var_number - 1] = w[4:0];
         end
      end else begin
         if (it.start_record) begin
            in_record  = 1'b1;
            bit_pos    = 1;
            value_wait = 1'b0;
            wait_index = '0;
         end
         if (in_record) begin
            ib = range_bits(index_range);
            if (ib > IDX_FIELD_BITS) ib = IDX_FIELD_BITS;
            if (value_wait) begin
               w = val_width[(int'(wait_index) - 1) % NUM_VARS];
               bit_pos = 1;
               out_q.push_back(make_pair(wait_index, take(it.packed_word, bit_pos, w),
                                         1'b1, 1'b0, 1'b0));
               bit_pos += w;
               value_wait = 1'b0;
            end
            forever begin
               if (out_q.size() >= RES_LIMIT) begin
                  bit_pos = 1;
                  break;
               end
               if (bit_pos + ib > WORD_BITS) begin
                  bit_pos = 1;
                  if (!it.packed_word[0]) begin
                     out_q.push_back(make_pair(0, 0, 1'b0, 1'b1, 1'b0));
                     in_record = 1'b0;
                  end
                  break;
               end
               idx = take(it.packed_word, bit_pos, ib);
               bit_pos += ib;
               if (idx == 0) begin
                  out_q.push_back(make_pair(0, 0, 1'b0, 1'b1, 1'b0));
                  in_record = 1'b0;
                  bit_pos = 1;
                  break;
               end
               if (idx > NUM_VARS) begin
                  out_q.push_back(make_pair(idx, 0, 1'b0, 1'b1, 1'b1));
                  in_record = 1'b0;
                  bit_pos = 1;
                  break;
               end
               w = val_width[idx - 1];
               if (bit_pos + w > WORD_BITS) begin
                  value_wait = 1'b1;
                  wait_index = idx[11:0];
                  bit_pos = 1;
                  break;
               end
               out_q.push_back(make_pair(idx, take(it.packed_word, bit_pos, w),
                                         1'b1, 1'b0, 1'b0));
               bit_pos += w;
            end
            if (out_q.size() != 0) out_q[$].last = 1'b1;
            foreach (out_q[k]) pairs_due.push_back(out_q[k]);
         end
      end
   endtask

   task automatic queue_load(input int unsigned num, input int unsigned rng);
      req_item_t it;
      int        w;
      it.func         = FUNC_LOAD;
      it.var_number   = num[10:0];
      it.var_range    = rng[16:0];
      it.packed_word  = $urandom;
      it.start_record = 1'($urandom_range(1));
      if (num >= 1 && num <= NUM_VARS) begin
         w = range_bits(rng[16:0]);
         plan_width[num - 1] = (w > MAX_VALUE_BITS) ? MAX_VALUE_BITS : w;
      end
      req_items.push_back(it);
      queued++;
      loads_sent++;
   endtask

   task automatic queue_word(input logic [31:0] wd, input logic start);
      req_item_t it;
      it.func         = FUNC_DECODE;
      it.var_number   = 11'($urandom);
      it.var_range    = 17'($urandom);
      it.packed_word  = wd;
      it.start_record = start;
      req_items.push_back(it);
      queued++;
      words_sent++;
   endtask

   // well-formed record with random content; cut leaves it unterminated
   task automatic queue_record(input int npairs, input bit cut);
      logic [31:0] wd;
      int          pos;
      int          hi;
      int          idx;
      int          w;
      bit          first;
      hi = (1 << plan_ib) - 1;
      if (hi > NUM_VARS) hi = NUM_VARS;
      wd = $urandom;
      pos = 1;
      first = 1'b1;
      for (int k = 0; k < npairs; k++) begin
         if (pos + plan_ib > WORD_BITS) begin
            wd[0] = 1'b1;
            queue_word(wd, first);
            first = 1'b0;
            wd = $urandom;
            pos = 1;
         end
         idx = $urandom_range(hi, 1);
         w = plan_width[idx - 1];
         wd = place(wd, pos, plan_ib, idx);
         pos += plan_ib;
         if (pos + w > WORD_BITS) begin
            queue_word(wd, first);
            first = 1'b0;
            wd = $urandom;
            pos = 1;
         end
         wd = place(wd, pos, w, $urandom);
         pos += w;
      end
      if (!cut) begin
         if (pos + plan_ib > WORD_BITS)
            wd[0] = 1'b0;
         else if (plan_ib > 10 && $urandom_range(3) == 0)
            wd = place(wd, pos, plan_ib, $urandom_range((1 << plan_ib) - 1, NUM_VARS + 1));
         else
            wd = place(wd, pos, plan_ib, 0);
      end
      queue_word(wd, first);
   endtask

   task automatic queue_random(input int n_items);
      int sel;
      int stop_at;
      stop_at = queued + n_items;
      while (queued < stop_at) begin
         sel = $urandom_range(99);
         if (sel < 62)
            queue_record($urandom_range(6), 1'b0);
         else if (sel < 72)
            queue_record($urandom_range(4), 1'b1);
         else if (sel < 84)
            queue_load(($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(NUM_VARS, 1),
                       $urandom_range(131071) >> $urandom_range(17));
         else
            queue_word($urandom, 1'($urandom_range(1)));
      end
   endtask

   task automatic write_index_range(input int unsigned v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v[CFG_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      index_range = v;
      plan_ib = range_bits(v);
      if (plan_ib > IDX_FIELD_BITS) plan_ib = IDX_FIELD_BITS;
   endtask

   task automatic drain();
      while (req_items.size() != 0 || req_tvalid || pairs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         failures++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_pairs(cur_req);
         if (!req_tvalid || req_tready) begin
            if (req_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_req = req_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {3'b000, cur_req.start_record, cur_req.packed_word,
                              cur_req.var_range, cur_req.var_number};
               req_tuser  <= cur_req.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      pair_rsp_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pairs_due.size() == 0) begin
            $error("unexpected result transaction: var_index %0d", rsp_tdata[11:0]);
            failures++;
         end else begin
            e = pairs_due.pop_front();
            check_field("var_index", e.var_index, rsp_tdata[11:0]);
            check_field("pair_value", e.pair_value, rsp_tdata[27:12]);
            check_field("pair_valid", e.pair_valid, rsp_tuser[0]);
            check_field("record_end", e.record_end, rsp_tuser[1]);
            check_field("index_error", e.index_error, rsp_tuser[2]);
            check_field("last", e.last, rsp_tlast);
            if (e.pair_valid) pairs_seen++;
            if (e.record_end) ends_seen++;
            if (e.index_error) errors_seen++;
         end
      end
   end

   initial begin
      #15_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      rsp_tready    = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      queued        = 0;
      failures      = 0;
      loads_sent    = 0;
      words_sent    = 0;
      pairs_seen    = 0;
      ends_seen     = 0;
      errors_seen   = 0;
      bit_pos       = 1;
      value_wait    = 1'b0;
      wait_index    = '0;
      in_record     = 1'b0;
      index_range   = 1024;
      plan_ib       = 10;
      foreach (val_width[i]) val_width[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_index_range(1024);
      for (int v = 1; v <= NUM_VARS; v++)
         queue_load(v, $urandom_range(131071) >> $urandom_range(17));

      // range extremes and ignored variable numbers
      queue_load(0, 5);
      queue_load(2047, 131071);
      queue_load(1025, 100);
      queue_load(1024, 65536);
      queue_load(1023, 131071);
      queue_load(1022, 0);
      queue_load(1021, 1);
      queue_load(1, 2);
      queue_load(2, 65535);
      // word with no open record
      queue_word(32'h1234_5678, 1'b0);
      queue_word(32'h0000_0000, 1'b1);
      // continuation set, then index zero on the next word
      queue_word(32'hFFFF_FFFF, 1'b1);
      queue_word(32'h0000_0001, 1'b0);
      // value split to the next word, dropped by a new record
      queue_word(place(place(place(32'hFFC0_0000, 1, 10, 1), 11, 1, 1), 12, 10, 1023), 1'b1);
      queue_word(32'h0000_0000, 1'b1);
      // value split to the next word, then completed
      queue_word(place(place(place(32'h0000_0000, 1, 10, 1), 11, 1, 0), 12, 10, 1023), 1'b1);
      queue_word(place(place(32'h0, 1, 16, 16'hABCD), 17, 10, 0), 1'b0);
      queue_record(3, 1'b0);
      queue_record(5, 1'b0);
      queue_record(0, 1'b0);
      drain();

      write_index_range($urandom_range(4095, 3));
      queue_random(36);
      drain();

      write_index_range(8191);
      send_idle_pct = 87;
      queue_word(32'hFFFF_FFFF, 1'b1);
      queue_random(36);
      drain();

      write_index_range(2);
      send_idle_pct = 0;
      rsp_stall_pct = 87;
      // densest word: one-bit index and value, most results per word
      queue_load(1, 2);
      queue_word(32'hFFFF_FFFF, 1'b1);
      queue_word(32'hFFFF_FFFE, 1'b0);
      queue_random(36);
      drain();

      write_index_range(4096);
      send_idle_pct = 28;
      rsp_stall_pct = 28;
      queue_random(36);
      drain();

      write_index_range(0);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      queue_random(36);
      drain();

      $display("covered %0d table loads and %0d packed words over six index ranges",
               loads_sent, words_sent);
      $display("checked %0d pairs, %0d record ends, %0d index errors",
               pairs_seen, ends_seen, errors_seen);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
src/dpu_pkg.sv
src/dpu_width_calc.sv
src/dpu_width_ram.sv
src/dpu_field_reader.sv
src/delta_pair_unpacker_core.sv
verif/tb_delta_pair_unpacker_core.sv
